[rtl/core/assert_macros.svh]
// Assertion macros shared by the barycentric weight datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define BCC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    `BCC_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

[rtl/core/bcc_pkg.sv]
// Package with widths, types and helpers of the barycentric weight datapath.
`timescale 1ns / 1ps
package bcc_pkg;
    localparam int COORD_W   = 12;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W - 1;
    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int QUO_W     = NUM_W + 1;
    localparam int SUM_W     = QUO_W + 2;
    localparam int WGT_W     = 32;

    localparam logic signed [SUM_W-1:0] ONE_Q16 = SUM_W'(1) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] WGT_MAX = SUM_W'({1'b0, {(WGT_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] WGT_MIN = -WGT_MAX - SUM_W'(1);

    typedef struct packed {
        logic [MAG_W-1:0] divisor;
        logic [MAG_W-1:0] rem_u;
        logic [MAG_W-1:0] rem_v;
        logic [NUM_W-1:0] dq_u;
        logic [NUM_W-1:0] dq_v;
        logic             neg_u;
        logic             neg_v;
        logic             degen;
    } t_div_word;

    function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [SUM_W-1:0] x);
        logic signed [WGT_W-1:0] r;
        if (x > WGT_MAX) begin
            r = {1'b0, {(WGT_W-1){1'b1}}};
        end else if (x < WGT_MIN) begin
            r = {1'b1, {(WGT_W-1){1'b0}}};
        end else begin
            r = x[WGT_W-1:0];
        end
        return r;
    endfunction
endpackage

[rtl/core/bcc_if.sv]
// Valid/ready interfaces for query words and weight words.
`timescale 1ns / 1ps
interface bcc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bcc_pkg::COORD_W-1:0]  point_x;
    logic signed [bcc_pkg::COORD_W-1:0]  point_y;
    logic signed [bcc_pkg::COORD_W-1:0]  vert_a_x;
    logic signed [bcc_pkg::COORD_W-1:0]  vert_a_y;
    logic signed [bcc_pkg::COORD_W-1:0]  vert_b_x;
    logic signed [bcc_pkg::COORD_W-1:0]  vert_b_y;
    logic signed [bcc_pkg::COORD_W-1:0]  vert_c_x;
    logic signed [bcc_pkg::COORD_W-1:0]  vert_c_y;

    modport source (output valid, point_x, point_y, vert_a_x, vert_a_y,
                    vert_b_x, vert_b_y, vert_c_x, vert_c_y, input ready);
    modport sink (input valid, point_x, point_y, vert_a_x, vert_a_y,
                  vert_b_x, vert_b_y, vert_c_x, vert_c_y, output ready);
endinterface

interface bcc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bcc_pkg::WGT_W-1:0]  weight_u;
    logic signed [bcc_pkg::WGT_W-1:0]  weight_v;
    logic signed [bcc_pkg::WGT_W-1:0]  weight_w;
    logic                              degenerate;

    modport source (output valid, weight_u, weight_v, weight_w, degenerate, input ready);
    modport sink (input valid, weight_u, weight_v, weight_w, degenerate, output ready);
endinterface

[rtl/core/barycentric_coordinates_2d.sv]
// Top level of the pipelined barycentric weight unit for 2D triangles.
//
//   Port       Dir   Word contents
//   i_item     in    point_x/y, vert_a_x/y, vert_b_x/y, vert_c_x/y
//   o_result   out   weight_u, weight_v, weight_w, degenerate
//
// One word is taken every cycle while the output is not stalled. Each word
// passes three setup stages, a row of 42 division cells (one quotient bit
// each) and two final stages. The whole pipeline advances together, so a
// stalled output word holds every stage in place and lowers i_item.ready.
// Reset is synchronous and clears only the stage valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module barycentric_coordinates_2d (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bcc_in_if.sink  i_item,
    bcc_out_if.source o_result
);
    import bcc_pkg::*;

    logic      w_en;
    logic      w_valid [0:NUM_W];
    t_div_word w_word  [0:NUM_W];

    assign w_en         = !o_result.valid || o_result.ready;
    assign i_item.ready = w_en;

    bcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_item.valid),
        .i_px    (i_item.point_x),
        .i_py    (i_item.point_y),
        .i_ax    (i_item.vert_a_x),
        .i_ay    (i_item.vert_a_y),
        .i_bx    (i_item.vert_b_x),
        .i_by    (i_item.vert_b_y),
        .i_cx    (i_item.vert_c_x),
        .i_cy    (i_item.vert_c_y),
        .o_valid (w_valid[0]),
        .o_word  (w_word[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        bcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_word  (w_word[g]),
            .o_valid (w_valid[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    bcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[NUM_W]),
        .i_word  (w_word[NUM_W]),
        .o_valid (o_result.valid),
        .o_u     (o_result.weight_u),
        .o_v     (o_result.weight_v),
        .o_w     (o_result.weight_w),
        .o_degen (o_result.degenerate)
    );

    `BCC_ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_result.valid && o_result.degenerate,
                      o_result.weight_u == '0 && o_result.weight_v == '0
                      && o_result.weight_w == '0, "degenerate word carries nonzero weights")
    `BCC_ASSERT(a_hold_on_stall, i_clk, i_rst_n,
                $past(!w_en) |-> $stable(w_valid[0]) && $stable(w_valid[NUM_W]),
                "pipeline moved while the output was stalled")
endmodule

[rtl/core/bcc_front.sv]
// Front stages: edge vectors, cross products and division operand setup.
`timescale 1ns / 1ps
module bcc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [bcc_pkg::COORD_W-1:0] i_px,
    input  logic [bcc_pkg::COORD_W-1:0] i_py,
    input  logic [bcc_pkg::COORD_W-1:0] i_ax,
    input  logic [bcc_pkg::COORD_W-1:0] i_ay,
    input  logic [bcc_pkg::COORD_W-1:0] i_bx,
    input  logic [bcc_pkg::COORD_W-1:0] i_by,
    input  logic [bcc_pkg::COORD_W-1:0] i_cx,
    input  logic [bcc_pkg::COORD_W-1:0] i_cy,
    output logic                       o_valid,
    output bcc_pkg::t_div_word         o_word
);
    import bcc_pkg::*;

    logic                      r_v1, r_v2, r_v3;
    logic signed [EDGE_W-1:0]  r_e0x, r_e0y, r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [CROSS_W-1:0] r_area, r_nu, r_nv;
    t_div_word                 r_word;
    logic signed [CROSS_W-1:0] n_area, n_nu, n_nv;
    logic [CROSS_W-1:0]        n_mag_a, n_mag_u, n_mag_v;

    function automatic logic signed [EDGE_W-1:0] sub_c(input logic [COORD_W-1:0] p,
                                                      input logic [COORD_W-1:0] q);
        return $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    endfunction

    always_comb begin
        n_area = CROSS_W'(r_e0x * r_e1y) - CROSS_W'(r_e0y * r_e1x);
        n_nu   = CROSS_W'(r_e2x * r_e1y) - CROSS_W'(r_e2y * r_e1x);
        n_nv   = CROSS_W'(r_e0x * r_e2y) - CROSS_W'(r_e0y * r_e2x);
        n_mag_a = r_area[CROSS_W-1] ? -r_area : r_area;
        n_mag_u = r_nu[CROSS_W-1] ? -r_nu : r_nu;
        n_mag_v = r_nv[CROSS_W-1] ? -r_nv : r_nv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e0x <= sub_c(i_bx, i_ax);
            r_e0y <= sub_c(i_by, i_ay);
            r_e1x <= sub_c(i_cx, i_ax);
            r_e1y <= sub_c(i_cy, i_ay);
            r_e2x <= sub_c(i_px, i_ax);
            r_e2y <= sub_c(i_py, i_ay);
            r_area <= n_area;
            r_nu   <= n_nu;
            r_nv   <= n_nv;
            r_word.divisor <= n_mag_a[MAG_W-1:0];
            r_word.rem_u   <= '0;
            r_word.rem_v   <= '0;
            r_word.dq_u    <= {n_mag_u[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            r_word.dq_v    <= {n_mag_v[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            r_word.neg_u   <= r_nu[CROSS_W-1] ^ r_area[CROSS_W-1];
            r_word.neg_v   <= r_nv[CROSS_W-1] ^ r_area[CROSS_W-1];
            r_word.degen   <= (r_area == '0);
        end
    end

    assign o_valid = r_v3;
    assign o_word  = r_word;
endmodule

[rtl/core/bcc_div_cell.sv]
// One restoring division cell: produces one quotient bit of both weights.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bcc_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  bcc_pkg::t_div_word i_word,
    output logic               o_valid,
    output bcc_pkg::t_div_word o_word
);
    import bcc_pkg::*;

    logic      r_valid;
    t_div_word r_word;
    t_div_word n_word;
    logic [MAG_W:0] n_try_u, n_try_v;
    logic           n_bit_u, n_bit_v;

    always_comb begin
        n_word  = i_word;
        n_try_u = {i_word.rem_u, i_word.dq_u[NUM_W-1]};
        n_try_v = {i_word.rem_v, i_word.dq_v[NUM_W-1]};
        n_bit_u = (n_try_u >= {1'b0, i_word.divisor});
        n_bit_v = (n_try_v >= {1'b0, i_word.divisor});
        n_word.rem_u = n_bit_u ? MAG_W'(n_try_u - {1'b0, i_word.divisor})
                               : n_try_u[MAG_W-1:0];
        n_word.rem_v = n_bit_v ? MAG_W'(n_try_v - {1'b0, i_word.divisor})
                               : n_try_v[MAG_W-1:0];
        n_word.dq_u = {i_word.dq_u[NUM_W-2:0], n_bit_u};
        n_word.dq_v = {i_word.dq_v[NUM_W-2:0], n_bit_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    `BCC_ASSERT_IMPLY(a_rem_u_below, i_clk, i_rst_n, r_valid && !r_word.degen,
                      r_word.rem_u < r_word.divisor, "partial remainder of u not reduced")
    `BCC_ASSERT_IMPLY(a_rem_v_below, i_clk, i_rst_n, r_valid && !r_word.degen,
                      r_word.rem_v < r_word.divisor, "partial remainder of v not reduced")
endmodule

[rtl/core/bcc_back.sv]
// Back stages: quotient signs, weight w and saturation into the output register.
`timescale 1ns / 1ps
module bcc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  bcc_pkg::t_div_word              i_word,
    output logic                            o_valid,
    output logic signed [bcc_pkg::WGT_W-1:0] o_u,
    output logic signed [bcc_pkg::WGT_W-1:0] o_v,
    output logic signed [bcc_pkg::WGT_W-1:0] o_w,
    output logic                            o_degen
);
    import bcc_pkg::*;

    logic                    r_v1, r_v2;
    logic signed [QUO_W-1:0] r_qu, r_qv;
    logic                    r_degen1;
    logic signed [QUO_W-1:0] n_qu, n_qv;
    logic signed [SUM_W-1:0] n_su, n_sv, n_sw;

    always_comb begin
        n_qu = $signed({1'b0, i_word.dq_u});
        n_qv = $signed({1'b0, i_word.dq_v});
        if (i_word.neg_u) begin
            n_qu = -n_qu;
        end
        if (i_word.neg_v) begin
            n_qv = -n_qv;
        end
        n_su = SUM_W'(r_qu);
        n_sv = SUM_W'(r_qv);
        n_sw = ONE_Q16 - n_su - n_sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qu     <= n_qu;
            r_qv     <= n_qv;
            r_degen1 <= i_word.degen;
            o_u      <= r_degen1 ? '0 : sat_wgt(n_su);
            o_v      <= r_degen1 ? '0 : sat_wgt(n_sv);
            o_w      <= r_degen1 ? '0 : sat_wgt(n_sw);
            o_degen  <= r_degen1;
        end
    end

    assign o_valid = r_v2;
endmodule

[tb/sv/bcc_checker.sv]
// Checker that predicts barycentric weights for each accepted query word and compares results.
`timescale 1ns / 1ps
module bcc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcc_in_if           i_item,
    bcc_out_if          i_result,
    output int          o_errors,
    output int          o_pending,
    output int          o_degen_seen,
    output int          o_sat_seen
);
    import bcc_pkg::*;

    typedef struct packed {
        logic signed [WGT_W-1:0] u;
        logic signed [WGT_W-1:0] v;
        logic signed [WGT_W-1:0] w;
        logic                    degen;
    } t_weights;

    t_weights expected_weights[$];

    function automatic logic signed [WGT_W-1:0] clamp_q16(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[WGT_W-1:0];
    endfunction

    function automatic t_weights solve_weights(
        input longint px, input longint py, input longint ax, input longint ay,
        input longint bx, input longint by, input longint cx, input longint cy);
        t_weights r;
        longint area, nu, nv, u, v;
        area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        nu = (px - ax) * (cy - ay) - (py - ay) * (cx - ax);
        nv = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
        if (area == 0) begin
            r = '{u: '0, v: '0, w: '0, degen: 1'b1};
        end else begin
            u = (nu * 65536) / area;
            v = (nv * 65536) / area;
            r.u = clamp_q16(u);
            r.v = clamp_q16(v);
            r.w = clamp_q16(64'sd65536 - u - v);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_degen_seen = 0;
        o_sat_seen = 0;
    end

    always @(posedge i_clk) begin
        t_weights e;
        if (i_rst_n && i_item.valid && i_item.ready) begin
            expected_weights.push_back(solve_weights(i_item.point_x, i_item.point_y,
                i_item.vert_a_x, i_item.vert_a_y, i_item.vert_b_x, i_item.vert_b_y,
                i_item.vert_c_x, i_item.vert_c_y));
        end
        if (i_rst_n && i_result.valid && i_result.ready) begin
            if (expected_weights.size() == 0) begin
                $error("weight word with no query pending");
                o_errors++;
            end else begin
                e = expected_weights.pop_front();
                if (e.degen) o_degen_seen++;
                if (e.u == 32'sh7fffffff || e.u == 32'sh80000000) o_sat_seen++;
                if (i_result.weight_u !== e.u) begin
                    $error("weight_u: expected %0d, got %0d", e.u, i_result.weight_u);
                    o_errors++;
                end
                if (i_result.weight_v !== e.v) begin
                    $error("weight_v: expected %0d, got %0d", e.v, i_result.weight_v);
                    o_errors++;
                end
                if (i_result.weight_w !== e.w) begin
                    $error("weight_w: expected %0d, got %0d", e.w, i_result.weight_w);
                    o_errors++;
                end
                if (i_result.degenerate !== e.degen) begin
                    $error("degenerate: expected %0d, got %0d", e.degen,
                           i_result.degenerate);
                    o_errors++;
                end
            end
        end
        o_pending = expected_weights.size();
    end
endmodule

[tb/sv/barycentric_coordinates_2d_tb.sv]
// Top of the barycentric weight testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module barycentric_coordinates_2d_tb;
    import bcc_pkg::*;

    localparam int LATENCY = 48;
    localparam int RANDOM_QUERIES = 1430;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending, degen_seen, sat_seen;
    int   cycles = 0;
    int   queries_sent = 0;
    bit   hold_output = 1'b0;

    bcc_in_if  query_ch();
    bcc_out_if weight_ch();

    barycentric_coordinates_2d i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (query_ch),
        .o_result (weight_ch)
    );

    bcc_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (query_ch),
        .i_result     (weight_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_degen_seen (degen_seen),
        .o_sat_seen   (sat_seen)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return gap_length();
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 12'h800;
            1: return 12'h7ff;
            2: return 12'(int'($urandom_range(0, 16)) - 8);
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_query(input logic [COORD_W-1:0] px, py, ax, ay, bx, by, cx, cy,
                              input bit keep);
        query_ch.point_x  <= px;
        query_ch.point_y  <= py;
        query_ch.vert_a_x <= ax;
        query_ch.vert_a_y <= ay;
        query_ch.vert_b_x <= bx;
        query_ch.vert_b_y <= by;
        query_ch.vert_c_x <= cx;
        query_ch.vert_c_y <= cy;
        query_ch.valid    <= 1'b1;
        do @(posedge i_clk); while (!query_ch.ready);
        queries_sent++;
        @(negedge i_clk);
        if (!keep) query_ch.valid <= 1'b0;
    endtask

    task automatic send_random(input int gap);
        logic [COORD_W-1:0] c[8];
        foreach (c[k]) c[k] = pick_coord();
        if ($urandom_range(0, 9) == 0) begin
            c[6] = c[2] + (c[4] - c[2]) * 12'($urandom_range(0, 3));
            c[7] = c[3] + (c[5] - c[3]) * 12'($urandom_range(0, 3));
        end
        send_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], gap == 0);
        repeat (gap) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_output) weight_ch.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8) weight_ch.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 3) weight_ch.ready <= 1'b0;
        else weight_ch.ready <= 1'b1;
    end

    initial begin
        query_ch.valid = 1'b0;
        {query_ch.point_x, query_ch.point_y, query_ch.vert_a_x, query_ch.vert_a_y} = '0;
        {query_ch.vert_b_x, query_ch.vert_b_y, query_ch.vert_c_x, query_ch.vert_c_y} = '0;
        weight_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_query(12'd0, 12'd0, 12'd0, 12'd0, 12'd10, 12'd0, 12'd0, 12'd10, 1'b1);
        send_query(12'd5, 12'd5, 12'd0, 12'd0, 12'd10, 12'd0, 12'd0, 12'd10, 1'b1);
        send_query(12'd3, 12'd3, 12'd0, 12'd0, 12'd0, 12'd0, 12'd7, 12'd9, 1'b1);
        send_query(12'd1, 12'd2, 12'd1, 12'd1, 12'd2, 12'd2, 12'd3, 12'd3, 1'b1);
        send_query(12'h7ff, 12'h7ff, 12'h800, 12'h800, 12'h7ff, 12'h800, 12'h800, 12'h7ff,
                   1'b1);
        send_query(12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'h800, 12'h7ff, 12'h7ff, 12'h800,
                   1'b1);
        send_query(12'h7ff, 12'h800, 12'd0, 12'd0, 12'd1, 12'd0, 12'd1, 12'd1, 1'b1);
        send_query(12'h800, 12'h7ff, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd1, 1'b1);
        send_query(12'h800, 12'h800, 12'd0, 12'd0, 12'd1, 12'd0, 12'd2, 12'd1, 1'b1);
        send_query(12'h7ff, 12'h7ff, 12'd0, 12'd0, 12'hfff, 12'd0, 12'd0, 12'hfff, 1'b1);
        send_query(12'hfff, 12'hfff, 12'h555, 12'haaa, 12'haaa, 12'h555, 12'h123, 12'hedc,
                   1'b1);
        send_query(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);

        // The sender waits here until the pipeline has drained completely.
        wait (pending == 0);
        @(negedge i_clk);

        fork
            begin
                hold_output = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_output = 1'b0;
            end
            for (int k = 0; k < 120; k++) send_random((k == 119) ? 1 : 0);
        join
        @(negedge i_clk);

        for (int k = 0; k < RANDOM_QUERIES - 120; k++) begin
            send_random((k == RANDOM_QUERIES - 121) ? 1 : random_gap());
        end

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d queries: %0d degenerate triangles, %0d saturated u weights.",
                 queries_sent, degen_seen, sat_seen);
        if (errors == 0 && pending == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[barycentric_coordinates_2d.f]
+incdir+rtl/core
rtl/core/bcc_pkg.sv
rtl/core/bcc_if.sv
rtl/core/bcc_front.sv
rtl/core/bcc_div_cell.sv
rtl/core/bcc_back.sv
rtl/core/barycentric_coordinates_2d.sv
tb/sv/bcc_checker.sv
tb/sv/barycentric_coordinates_2d_tb.sv
